[rtl/chordal_catmull_rom_evaluator_assert.svh]
// ============================================================================
// Assertion macros for the chordal Catmull-Rom evaluator
// Shared property wrappers used at the end of the evaluator module.
// ============================================================================
`ifndef CHORDAL_CATMULL_ROM_EVALUATOR_ASSERT_SVH
`define CHORDAL_CATMULL_ROM_EVALUATOR_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define CCR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CCR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ccr_pkg.sv]
// ============================================================================
// ccr_pkg
// Widths, codes and control types for the chordal Catmull-Rom evaluator.
// ============================================================================
package ccr_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FEW      = 2'd1;
  localparam logic [1:0] STATUS_COINCIDE = 2'd2;

  localparam logic ACTION_PUSH = 1'b0;
  localparam logic ACTION_EVAL = 1'b1;

  // Operation codes of the shared serial unit.
  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_DIV  = 3'b010,
    OP_SQRT = 3'b100
  } ccr_op_t;

  typedef struct packed {
    logic    start;
    ccr_op_t op;
  } ccr_ctl_t;
endpackage

[rtl/ccr_stream_if.sv]
// ============================================================================
// ccr_stream_if
// Valid/ready channel carrying one payload per beat.
// ============================================================================
interface ccr_stream_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/ccr_serial_unit.sv]
// ============================================================================
// ccr_serial_unit
// Shared bit-serial multiply, divide and square root, one bit per cycle.
// ============================================================================
module ccr_serial_unit import ccr_pkg::*; #(
  parameter int W = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  ccr_ctl_t     ctl,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         busy,
  output logic [W-1:0] res
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc;
  logic [W-1:0]  opa;
  logic [W-1:0]  opb;
  logic [W+1:0]  rem;
  logic [CW-1:0] cnt;
  ccr_op_t       op;

  logic [W+1:0] rem_sh;
  logic [W+1:0] trial;
  logic [W+1:0] rem_sq;
  logic [W+1:0] trial_sq;

  // Restoring division brings in one numerator bit; square root two bits.
  always_comb begin
    rem_sh   = {rem[W:0], opa[W-1]};
    trial    = rem_sh - {2'b00, opb};
    rem_sq   = {rem[W-1:0], opa[W-1:W-2]};
    trial_sq = rem_sq - {acc, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      op   <= OP_MUL;
    end else if (ctl.start && !busy) begin
      busy <= 1'b1;
      op   <= ctl.op;
      opa  <= a;
      opb  <= b;
      acc  <= '0;
      rem  <= '0;
      cnt  <= (ctl.op == OP_SQRT) ? CW'(W / 2) : CW'(W);
    end else if (busy) begin
      case (op)
        OP_MUL: begin
          // shift-add, multiplier msb first
          acc <= (acc << 1) + (opa[W-1] ? opb : '0);
          opa <= opa << 1;
        end
        OP_DIV: begin
          if (!trial[W+1]) begin
            rem <= trial;
            acc <= {acc[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            acc <= {acc[W-2:0], 1'b0};
          end
          opa <= opa << 1;
        end
        OP_SQRT: begin
          if (!trial_sq[W+1]) begin
            rem <= trial_sq;
            acc <= {acc[W-2:0], 1'b1};
          end else begin
            rem <= rem_sq;
            acc <= {acc[W-2:0], 1'b0};
          end
          opa <= opa << 2;
        end
        default: acc <= acc;
      endcase
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  assign res = acc;
endmodule

[rtl/chordal_catmull_rom_evaluator.sv]
// One push taken every cycle while idle; an evaluate with fewer than four points goes
// straight to its result beat. An evaluate with coincident points stops after the chord
// lengths; a full evaluate runs 45 operations in the shared bit-serial unit, plus one
// rounding step per axis.
// One item in flight; the next input is taken the cycle after the result beat.
// rst (synchronous) clears the window, the point count and the handshakes.
// ============================================================================
// chordal_catmull_rom_evaluator
// Chordal Catmull-Rom segment evaluation through one serial arithmetic unit.
// ============================================================================
module chordal_catmull_rom_evaluator import ccr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  ccr_stream_if.sink   in_ch,
  ccr_stream_if.source out_ch
);
  `include "chordal_catmull_rom_evaluator_assert.svh"

  localparam int CW = COORD_WIDTH;
  localparam int W  = 2 * CW + 2 * T_FRAC_BITS + 16;
  localparam int VW = CW + 4;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIST = 6'b000010,
    ST_TANG = 6'b000100,
    ST_HORN = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic signed [CW-1:0] wx [4];
  logic signed [CW-1:0] wy [4];
  logic signed [CW-1:0] wz [4];
  logic [2:0]  held;
  logic [T_FRAC_BITS:0] tval;
  logic [W-1:0] dlen [3];
  logic [1:0]  axis;
  logic [1:0]  pair;
  logic [4:0]  step;
  logic signed [W-1:0] m1, m2, tmp, accv;
  logic [W-1:0] ua, ub;
  logic        neg;
  ccr_ctl_t    ctl;
  logic        busy, busy_q;
  logic [W-1:0] res;
  logic signed [CW-1:0] ox, oy, oz;
  logic [1:0]  ost;

  ccr_serial_unit #(.W(W)) u_ser (
    .clk(clk), .rst(rst), .ctl(ctl), .a(ua), .b(ub), .busy(busy), .res(res)
  );

  // Window point k of the current axis, sign extended.
  function automatic logic signed [W-1:0] wp(input logic [1:0] ax, input int k,
      input logic signed [CW-1:0] x [4], input logic signed [CW-1:0] y [4],
      input logic signed [CW-1:0] z [4]);
    case (ax)
      2'd0:    wp = W'(x[k]);
      2'd1:    wp = W'(y[k]);
      default: wp = W'(z[k]);
    endcase
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [W-1:0] v);
    logic signed [W-1:0] hi, lo;
    hi = W'((W'(1) <<< (CW - 1)) - 1);
    lo = -hi - W'(1);
    if (v > hi) sat = hi[CW-1:0];
    else if (v < lo) sat = lo[CW-1:0];
    else sat = v[CW-1:0];
  endfunction

  logic start_ok;
  assign in_ch.ready = (state == ST_IDLE) && !out_ch.valid;
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.data = {ox, oy, oz, ost};

  logic signed [W-1:0] p0, p1, p2, p3, dd;
  always_comb begin
    p0 = wp(axis, 0, wx, wy, wz);
    p1 = wp(axis, 1, wx, wy, wz);
    p2 = wp(axis, 2, wx, wy, wz);
    p3 = wp(axis, 3, wx, wy, wz);
    dd = p1 - p2;
  end

  // One serial operation finishes when busy falls.
  logic done;
  assign done = busy_q && !busy;
  assign start_ok = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      held   <= '0;
      ctl    <= '{start: 1'b0, op: OP_MUL};
      busy_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        wx[i] <= '0; wy[i] <= '0; wz[i] <= '0;
      end
    end else begin
      busy_q <= busy | ctl.start;
      // start is a one-cycle pulse; no operation is issued while it is high
      if (ctl.start) ctl.start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready && start_ok) begin
            if (in_ch.data.action == ACTION_PUSH) begin
              for (int i = 0; i < 3; i++) begin
                wx[i] <= wx[i+1]; wy[i] <= wy[i+1]; wz[i] <= wz[i+1];
              end
              wx[3] <= in_ch.data.coord_x;
              wy[3] <= in_ch.data.coord_y;
              wz[3] <= in_ch.data.coord_z;
              if (held < 3'd4) held <= held + 3'd1;
            end else begin
              ox <= wx[1]; oy <= wy[1]; oz <= wz[1];
              tval <= (in_ch.data.eval_t > (T_FRAC_BITS+1)'(1 << T_FRAC_BITS)) ?
                      (T_FRAC_BITS+1)'(1 << T_FRAC_BITS) : in_ch.data.eval_t;
              if (held < 3'd4) begin
                ost   <= STATUS_FEW;
                state <= ST_OUT;
              end else begin
                step  <= '0;
                pair  <= '0;
                axis  <= 2'd0;
                state <= ST_DIST;
              end
            end
          end
        end
        // Distances: per pair, three squares summed, then a square root.
        ST_DIST: begin
          if (!busy_q && !ctl.start) begin
            if (step < 5'd3) begin
              ctl  <= '{start: 1'b1, op: OP_MUL};
              ua   <= mag(wp(step[1:0], int'(pair)+1, wx, wy, wz)
                        - wp(step[1:0], int'(pair), wx, wy, wz));
              ub   <= mag(wp(step[1:0], int'(pair)+1, wx, wy, wz)
                        - wp(step[1:0], int'(pair), wx, wy, wz));
            end else begin
              ctl <= '{start: 1'b1, op: OP_SQRT};
              ua  <= tmp;
            end
          end else if (done) begin
            if (step < 5'd3) begin
              tmp <= (step == 5'd0) ? res : tmp + res;
              step <= step + 5'd1;
            end else begin
              dlen[pair] <= res;
              if (pair == 2'd2) begin
                if (dlen[0] == '0 || res == '0) begin
                  ost <= STATUS_COINCIDE;
                  state <= ST_OUT;
                end else begin
                  axis <= 2'd0; step <= '0; state <= ST_TANG;
                end
              end else begin
                pair <= pair + 2'd1;
                step <= '0;
              end
            end
          end
        end
        // Tangent ratio terms: multiply by d12, then divide by denominator.
        ST_TANG: begin
          logic [1:0] term;
          logic signed [W-1:0] v;
          logic [W-1:0] den;
          term = step[2:1];
          case (term)
            2'd0: begin v = p1 - p0; den = dlen[0]; end
            2'd1: begin v = p2 - p0; den = dlen[0] + dlen[1]; end
            2'd2: begin v = p3 - p2; den = dlen[2]; end
            default: begin v = p3 - p1; den = dlen[1] + dlen[2]; end
          endcase
          if (!busy_q && !ctl.start) begin
            if (!step[0]) begin
              neg <= v[W-1];
              ctl <= '{start: 1'b1, op: OP_MUL};
              ua  <= mag(v); ub <= dlen[1];
            end else begin
              ctl <= '{start: 1'b1, op: OP_DIV};
              ua  <= tmp; ub <= den;
            end
          end else if (done) begin
            if (!step[0]) begin
              tmp  <= res;
              step <= step + 5'd1;
            end else begin
              case (term)
                2'd0: m1 <= (p2 - p1) + (neg ? -W'(res) : W'(res));
                2'd1: m1 <= m1 - (neg ? -W'(res) : W'(res));
                2'd2: m2 <= (p2 - p1) + (neg ? -W'(res) : W'(res));
                default: m2 <= m2 - (neg ? -W'(res) : W'(res));
              endcase
              if (term == 2'd3) begin
                step <= '0;
                accv <= 4 * dd + m1 + m2 - (neg ? -W'(res) : W'(res));
                state <= ST_HORN;
              end else step <= step + 5'd1;
            end
          end
        end
        // Horner steps with rounding, ties away from zero.
        ST_HORN: begin
          logic signed [W-1:0] rnd;
          if (!busy_q && !ctl.start) begin
            neg <= accv[W-1];
            ctl <= '{start: 1'b1, op: OP_MUL};
            ua  <= mag(accv); ub <= W'(tval);
          end else if (done) begin
            rnd = W'((res + (W'(1) << (T_FRAC_BITS - 1))) >> T_FRAC_BITS);
            rnd = neg ? -rnd : rnd;
            case (step[1:0])
              2'd0: accv <= rnd - 6 * dd - 2 * m1 - m2;
              2'd1: accv <= rnd + m1;
              default: accv <= rnd + 2 * p1;
            endcase
            step <= step + 5'd1;
            if (step[1:0] == 2'd2) state <= ST_WAIT;
          end
        end
        // Halve, round, saturate one axis, then move to the next, or to the result after the last.
        ST_WAIT: begin
          logic signed [W-1:0] rnd;
          rnd = W'((mag(accv) + W'(1)) >> 1);
          rnd = accv[W-1] ? -rnd : rnd;
          case (axis)
            2'd0: ox <= sat(rnd);
            2'd1: oy <= sat(rnd);
            default: oz <= sat(rnd);
          endcase
          if (axis == 2'd2) begin
            ost <= STATUS_OK; state <= ST_OUT;
          end else begin
            axis <= axis + 2'd1; step <= '0; state <= ST_TANG;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CCR_ASSERT_IMP(a_no_accept_busy, state != ST_IDLE, !in_ch.ready)
  `CCR_ASSERT_IMP(a_held_max, 1'b1, held <= 3'd4)
  `CCR_ASSERT_NXT(a_out_leaves, out_ch.valid && out_ch.ready, state == ST_IDLE)
endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// Chordal Catmull-Rom evaluator testbench
// Pushes control points and evaluates the curve through the two valid/ready
// channels, predicts each evaluated point in fixed point and checks every
// result beat in order. Idling on both sides varies over three phases.
// ============================================================================
module testbench;
  import ccr_pkg::*;

  typedef struct packed {
    logic               action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [16:0]        eval_t;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
  } point_t;

  // Predicts evaluated points and holds them until their result beats arrive
  class curve_scoreboard;
    longint   win_x[4];
    longint   win_y[4];
    longint   win_z[4];
    int       held;
    point_t   expected_points[$];
    int       errors;

    function new();
      for (int i = 0; i < 4; i++) begin
        win_x[i] = 0; win_y[i] = 0; win_z[i] = 0;
      end
      held = 0;
      errors = 0;
    endfunction

    function logic [127:0] mag(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m;
    endfunction

    function logic [63:0] root_floor(logic [127:0] n);
      logic [63:0] r;
      logic [127:0] c;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
        c = 128'(r | (64'd1 << b));
        if (c * c <= n) r = c[63:0];
      end
      return r;
    endfunction

    function logic [63:0] chord(int a, int b);
      logic [127:0] s;
      s = mag(win_x[a] - win_x[b]) * mag(win_x[a] - win_x[b])
        + mag(win_y[a] - win_y[b]) * mag(win_y[a] - win_y[b])
        + mag(win_z[a] - win_z[b]) * mag(win_z[a] - win_z[b]);
      return root_floor(s);
    endfunction

    // v*num/den truncated toward zero, quotient capped at 2^62
    function longint scaled(longint v, logic [63:0] num, logic [63:0] den);
      logic [127:0] q;
      q = (mag(v) * 128'(num)) / 128'(den);
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      return (v < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function longint horner(longint acc, logic [63:0] t, longint addend);
      logic [127:0] p;
      longint r;
      p = mag(acc) * 128'(t) + (128'd1 << 15);
      r = longint'(p[79:16]);
      return ((acc < 0) ? -r : r) + addend;
    endfunction

    function logic [31:0] clamp(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function logic [31:0] axis(longint w[4], logic [63:0] d01, logic [63:0] d12,
                               logic [63:0] d23, logic [63:0] t);
      longint m1, m2, dd, acc;
      logic [127:0] h;
      m1 = (w[2] - w[1]) + scaled(w[1] - w[0], d12, d01)
         - scaled(w[2] - w[0], d12, d01 + d12);
      m2 = (w[2] - w[1]) + scaled(w[3] - w[2], d12, d23)
         - scaled(w[3] - w[1], d12, d12 + d23);
      dd = w[1] - w[2];
      acc = 4 * dd + m1 + m2;
      acc = horner(acc, t, -6 * dd - 2 * m1 - m2);
      acc = horner(acc, t, m1);
      acc = horner(acc, t, 2 * w[1]);
      h = (mag(acc) + 1) >> 1;
      return clamp((acc < 0) ? -longint'(h[63:0]) : longint'(h[63:0]));
    endfunction

    function void note_item(cmd_t c);
      point_t p;
      logic [63:0] d01, d12, d23, t;
      if (c.action == ACTION_PUSH) begin
        for (int i = 0; i < 3; i++) begin
          win_x[i] = win_x[i+1]; win_y[i] = win_y[i+1]; win_z[i] = win_z[i+1];
        end
        win_x[3] = c.coord_x; win_y[3] = c.coord_y; win_z[3] = c.coord_z;
        if (held < 4) held++;
        return;
      end
      p.out_x = clamp(win_x[1]);
      p.out_y = clamp(win_y[1]);
      p.out_z = clamp(win_z[1]);
      p.status = STATUS_FEW;
      if (held >= 4) begin
        d01 = chord(0, 1);
        d12 = chord(1, 2);
        d23 = chord(2, 3);
        if (d01 == 0 || d23 == 0) begin
          p.status = STATUS_COINCIDE;
        end else begin
          t = (c.eval_t > 17'd65536) ? 64'd65536 : 64'(c.eval_t);
          p.out_x = axis(win_x, d01, d12, d23, t);
          p.out_y = axis(win_y, d01, d12, d23, t);
          p.out_z = axis(win_z, d01, d12, d23, t);
          p.status = STATUS_OK;
        end
      end
      expected_points.push_back(p);
    endfunction

    function void check_point(point_t got);
      point_t e;
      if (expected_points.size() == 0) begin
        $error("result beat with no evaluation pending");
        errors++;
        return;
      end
      e = expected_points.pop_front();
      if (got.out_x !== e.out_x) begin
        $error("out_x expected %0d actual %0d", e.out_x, got.out_x); errors++;
      end
      if (got.out_y !== e.out_y) begin
        $error("out_y expected %0d actual %0d", e.out_y, got.out_y); errors++;
      end
      if (got.out_z !== e.out_z) begin
        $error("out_z expected %0d actual %0d", e.out_z, got.out_z); errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_cycles;
  curve_scoreboard sb;
  cmd_t last_push;

  ccr_stream_if #(.PAYLOAD_T(cmd_t))   in_ch();
  ccr_stream_if #(.PAYLOAD_T(point_t)) out_ch();

  chordal_catmull_rom_evaluator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Beat monitors
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_item(in_ch.data);
    if (!rst && out_ch.valid && out_ch.ready) sb.check_point(out_ch.data);
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 60000) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send(cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= c;
    do @(posedge clk); while (!in_ch.ready);
    if (c.action == ACTION_PUSH) last_push = c;
  endtask

  task automatic push(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    cmd_t c;
    c = '0;
    c.action = ACTION_PUSH;
    c.coord_x = x; c.coord_y = y; c.coord_z = z;
    c.eval_t = 17'($urandom);
    send(c);
  endtask

  task automatic evaluate(logic [16:0] t);
    cmd_t c;
    c.action = ACTION_EVAL;
    c.coord_x = $urandom; c.coord_y = $urandom; c.coord_z = $urandom;
    c.eval_t = t;
    send(c);
  endtask

  // Let the monitor note the last beat, then wait until no evaluated point is pending
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_points.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom_range(2097151) - 1048576;
    if (sel < 7) return $urandom_range(268435455) - 134217728;
    return $urandom;
  endfunction

  function automatic logic [16:0] rand_t();
    if ($urandom_range(9) == 0) return 17'($urandom);
    return 17'($urandom_range(65536));
  endfunction

  task automatic random_items(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 62) push(rand_coord(), rand_coord(), rand_coord());
      else if (sel < 70) push(last_push.coord_x, last_push.coord_y, last_push.coord_z);
      else evaluate(rand_t());
    end
  endtask

  initial begin
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    last_push = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: too few points, extremes, coincident points, t corners
    evaluate(17'd0);
    push(32'h7fffffff, 32'h80000000, 32'h00010000);
    evaluate(17'd65536);
    push(32'h80000000, 32'h7fffffff, 32'hffff0000);
    push(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    evaluate(17'd32768);
    push(32'h80000000, 32'h80000000, 32'h80000000);
    evaluate(17'd0);
    evaluate(17'd65536);
    evaluate(17'h1ffff);
    evaluate(17'd1);
    push(32'h80000000, 32'h80000000, 32'h80000000);
    evaluate(17'd40000);
    push(32'h00010000, 32'h00020000, 32'h00030000);
    push(32'h00010000, 32'h00020000, 32'h00030000);
    push(32'h00050000, 32'hfffe0000, 32'h00000000);
    evaluate(17'd20000);
    push(32'h00090000, 32'h00010000, 32'h00040000);
    evaluate(17'd50000);
    evaluate(17'd65537);
    push(32'h00090000, 32'h00010000, 32'h00040000);
    evaluate(17'd30000);
    drain();

    send_idle_pct = 11; recv_idle_pct = 83;
    random_items(360);
    drain();
    send_idle_pct = 83; recv_idle_pct = 11;
    random_items(360);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_items(360);
    drain();
    repeat (100) @(posedge clk);

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[chordal_catmull_rom_evaluator.f]
+incdir+rtl
rtl/ccr_pkg.sv
rtl/ccr_stream_if.sv
rtl/ccr_serial_unit.sv
rtl/chordal_catmull_rom_evaluator.sv
dv/testbench.sv
